/* rtl/rlb_pkg.sv */
// ----------------------------------------------------------------------------
// rlb_pkg
// Types, constants and channel arithmetic shared by the line blur modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rlb_pkg;

  localparam int unsigned CH_W          = 8;
  localparam logic [7:0]  CH_MAX        = 8'd255;
  localparam int unsigned QUEUE_DEPTH_D = 4;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       line_end;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       line_done;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // one classified pixel travelling from front to back
  typedef struct packed {
    rgb_t seep_part;
    rgb_t keep_part;
    logic line_end;
  } mid_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // (v * (s + 1)) >> 8, never above 255
  function automatic logic [7:0] scale_ch(input logic [7:0] v, input logic [7:0] s);
    logic [16:0] prod;
    prod = {9'd0, v} * ({9'd0, s} + 17'd1);
    return prod[15:8];
  endfunction

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[8] ? CH_MAX : sum[7:0];
  endfunction

  function automatic rgb_t scale_px(input rgb_t p, input logic [7:0] s);
    rgb_t q;
    q.r = scale_ch(p.r, s);
    q.g = scale_ch(p.g, s);
    q.b = scale_ch(p.b, s);
    return q;
  endfunction

  function automatic rgb_t sat_add_px(input rgb_t a, input rgb_t b);
    rgb_t q;
    q.r = sat_add(a.r, b.r);
    q.g = sat_add(a.g, b.g);
    q.b = sat_add(a.b, b.b);
    return q;
  endfunction

endpackage

`default_nettype wire

/* rtl/rlb_fifo.sv */
// ----------------------------------------------------------------------------
// rlb_fifo
// Small first-word-fall-through queue, one write and one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rlb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd,
  output logic      [WIDTH-1:0] rd_data,
  output rlb_pkg::q_status_t    status
);
  import rlb_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  // DEPTH must be a power of two to let the pointers wrap; this is not enforced
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      case ({wr, rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  assign rd_data      = mem[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == CW'(DEPTH));

endmodule

`default_nettype wire

/* rtl/rlb_front.sv */
// ----------------------------------------------------------------------------
// rlb_front
// Takes pixels in and splits each channel into its seep and keep parts.
// ----------------------------------------------------------------------------
`default_nettype none

module rlb_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         spread,
  input  wire logic               push,
  output logic                    full,
  input  wire rlb_pkg::pix_in_t   pixel,
  input  wire rlb_pkg::q_status_t mid_status,
  output logic                    mid_wr,
  output rlb_pkg::mid_item_t      mid_data
);
  import rlb_pkg::*;

  logic       stage_valid;
  mid_item_t  stage;
  mid_item_t  stage_next;
  logic       load;
  logic [7:0] keep;
  logic [7:0] seep;
  rgb_t       px;

  assign keep = CH_MAX - spread;
  assign seep = {1'b0, spread[7:1]};

  assign px.r = pixel.red_in;
  assign px.g = pixel.green_in;
  assign px.b = pixel.blue_in;

  always_comb begin
    stage_next.seep_part = scale_px(px, seep);
    stage_next.keep_part = scale_px(px, keep);
    stage_next.line_end  = pixel.line_end;
  end

  assign mid_wr = stage_valid && !mid_status.full;
  assign load   = !stage_valid || !mid_status.full;
  assign full   = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (load) begin
      stage_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (load && push) begin
      stage <= stage_next;
    end
  end

  assign mid_data = stage;

endmodule

`default_nettype wire

/* rtl/rlb_back.sv */
// ----------------------------------------------------------------------------
// rlb_back
// Holds line state and finishes pixels, one result a cycle when not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module rlb_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rlb_pkg::q_status_t mid_status,
  input  wire rlb_pkg::mid_item_t mid_data,
  output logic                    mid_rd,
  input  wire rlb_pkg::q_status_t out_status,
  output logic                    out_wr,
  output rlb_pkg::pix_out_t       out_data
);
  import rlb_pkg::*;

  rgb_t pending;
  rgb_t carry;
  logic have_pending;
  logic second;
  rgb_t cur;
  rgb_t fin;
  logic go;
  logic emit_prev;

  assign cur       = sat_add_px(mid_data.keep_part, carry);
  assign fin       = sat_add_px(pending, mid_data.seep_part);
  assign go        = !mid_status.empty && !out_status.full;
  assign emit_prev = have_pending && !second;

  // a line end after other pixels gives two results, so it is read only with the second
  assign mid_rd = go && !(emit_prev && mid_data.line_end);
  assign out_wr = go && (emit_prev || mid_data.line_end);

  always_comb begin
    if (emit_prev) begin
      out_data.red_out   = fin.r;
      out_data.green_out = fin.g;
      out_data.blue_out  = fin.b;
      out_data.line_done = 1'b0;
    end else begin
      out_data.red_out   = cur.r;
      out_data.green_out = cur.g;
      out_data.blue_out  = cur.b;
      out_data.line_done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending      <= '0;
      carry        <= '0;
      have_pending <= 1'b0;
      second       <= 1'b0;
    end else if (mid_rd) begin
      second <= 1'b0;
      if (mid_data.line_end) begin
        pending      <= '0;
        carry        <= '0;
        have_pending <= 1'b0;
      end else begin
        pending      <= cur;
        carry        <= mid_data.seep_part;
        have_pending <= 1'b1;
      end
    end else if (go) begin
      second <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/rgb_line_blur_core.sv */
// ----------------------------------------------------------------------------
// rgb_line_blur_core
// Three-tap blur over a streamed line of RGB888 pixels, weighted by spread.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and gives one result per clock unless a queue
// is full. The front stage scales each channel and registers the parts,
// which pass through a short queue to the back stage. That stage keeps the
// line state and writes results into the output queue. A last pixel that
// follows others on its line yields two results and holds the back stage
// until both are written. spread is written on the cfg channel
// (always ready) and must only change while no pixel is in flight.
`default_nettype none

module rgb_line_blur_core #(
  parameter int unsigned QUEUE_DEPTH = rlb_pkg::QUEUE_DEPTH_D
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire rlb_pkg::pix_in_t  pixel,
  output logic                   empty,
  input  wire logic              pop,
  output rlb_pkg::pix_out_t      result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [7:0]        cfg_data
);
  import rlb_pkg::*;

  logic      [7:0] spread;
  q_status_t       mid_status;
  q_status_t       out_status;
  logic            mid_wr;
  logic            mid_rd;
  mid_item_t       mid_wr_data;
  mid_item_t       mid_rd_data;
  logic            out_wr;
  pix_out_t        out_wr_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      spread <= '0;
    end else if (cfg_valid && cfg_ready) begin
      spread <= cfg_data;
    end
  end

  rlb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .spread     (spread),
    .push       (push),
    .full       (full),
    .pixel      (pixel),
    .mid_status (mid_status),
    .mid_wr     (mid_wr),
    .mid_data   (mid_wr_data)
  );

  rlb_fifo #(
    .WIDTH($bits(mid_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_q (
    .clk    (clk),
    .rst    (rst),
    .wr     (mid_wr),
    .wr_data(mid_wr_data),
    .rd     (mid_rd),
    .rd_data(mid_rd_data),
    .status (mid_status)
  );

  rlb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_status(mid_status),
    .mid_data  (mid_rd_data),
    .mid_rd    (mid_rd),
    .out_status(out_status),
    .out_wr    (out_wr),
    .out_data  (out_wr_data)
  );

  rlb_fifo #(
    .WIDTH($bits(pix_out_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_q (
    .clk    (clk),
    .rst    (rst),
    .wr     (out_wr),
    .wr_data(out_wr_data),
    .rd     (pop && !out_status.empty),
    .rd_data(result),
    .status (out_status)
  );

  assign empty = out_status.empty;

endmodule

`default_nettype wire

/* rtl/rlb_checker.sv */
// ----------------------------------------------------------------------------
// rlb_checker
// Port-level checks on the line blur core, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rlb_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              full,
  input wire logic              empty,
  input wire logic              pop,
  input wire rlb_pkg::pix_out_t result,
  input wire logic              cfg_ready
);
  import rlb_pkg::*;

  // nothing is waiting straight after reset
  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  a_room_after_rst: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  // a waiting beat stays put until it is popped
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("cfg channel not ready");

endmodule

bind rgb_line_blur_core rlb_checker u_rlb_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .result   (result),
  .cfg_ready(cfg_ready)
);

`default_nettype wire
